>>> rtl/assert_macros.svh
// Assertion macros shared by the interpolator RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TLI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TLI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tli_pkg.sv
// Types, codes and helpers of the trajectory linear interpolator.
// No dependencies.
`timescale 1ns / 1ps
package tli_pkg;

  localparam logic [1:0] KIND_BEGIN  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  localparam logic [1:0] STAT_INTERP = 2'd0;
  localparam logic [1:0] STAT_HELD   = 2'd1;
  localparam logic [1:0] STAT_EMPTY  = 2'd2;

  localparam logic [1:0] REG_START_POS = 2'd0;
  localparam logic [1:0] REG_START_VEL = 2'd1;
  localparam logic [1:0] REG_START_EFF = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_BLEND,
    ST_OUT
  } tli_state_e;

  typedef enum logic [2:0] {
    BL_IDLE,
    BL_PREP,
    BL_MUL,
    BL_SUM,
    BL_DIV,
    BL_FIN,
    BL_DONE
  } tli_blend_state_e;

  // Saturate a 34-bit two's complement value to 32 bits.
  function automatic logic [31:0] tli_sat32(input logic [33:0] v);
    logic [31:0] r;
    if (!v[33] && (v[32:31] != 2'b00)) r = 32'h7FFF_FFFF;
    else if (v[33] && (v[32:31] != 2'b11)) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

>>> rtl/tli_point_ram.sv
// Point table memory: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
module tli_point_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 168
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/tli_blend_unit.sv
// Serial blend unit: a + round((b - a) * n / d), saturated to 32 bits.
// Uses tli_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tli_blend_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] n_i,
  input  logic [31:0] d_i,
  output logic        done_o,
  output logic [31:0] result_o
);
  import tli_pkg::*;

  tli_blend_state_e state_q, state_d;

  logic [31:0] a_q, b_q, n_q, d_q;
  logic        neg_q;
  logic [31:0] mag_q;
  logic [63:0] prod_q;
  logic [31:0] rem_q, quo_q;
  logic [4:0]  cnt_q;
  logic [31:0] result_q;

  logic [32:0] delta;
  logic [63:0] prod;
  logic [63:0] sum;
  logic [33:0] trial;
  logic [33:0] fin;

  assign delta = {b_q[31], b_q} - {a_q[31], a_q};
  assign prod  = mag_q * n_q;
  assign sum   = prod_q + {33'd0, d_q[31:1]};
  assign trial = {1'b0, rem_q, quo_q[31]} - {2'b00, d_q};
  assign fin   = neg_q ? ({{2{a_q[31]}}, a_q} - {2'b00, quo_q})
                       : ({{2{a_q[31]}}, a_q} + {2'b00, quo_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BL_IDLE: begin
        if (start_i) state_d = (d_i == 32'd0) ? BL_DONE : BL_PREP;
      end
      BL_PREP: state_d = BL_MUL;
      BL_MUL:  state_d = BL_SUM;
      BL_SUM:  state_d = BL_DIV;
      BL_DIV: begin
        if (cnt_q == 5'd0) state_d = BL_FIN;
      end
      BL_FIN:  state_d = BL_DONE;
      BL_DONE: state_d = BL_IDLE;
      default: state_d = BL_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BL_IDLE: begin
        if (start_i) begin
          a_q      <= a_i;
          b_q      <= b_i;
          n_q      <= n_i;
          d_q      <= d_i;
          result_q <= b_i;  // zero-length segment gives the target
        end
      end
      BL_PREP: begin
        neg_q <= delta[32];
        mag_q <= delta[32] ? 32'(-delta) : delta[31:0];
      end
      BL_MUL: prod_q <= prod;
      BL_SUM: begin
        rem_q <= sum[63:32];
        quo_q <= sum[31:0];
        cnt_q <= 5'd31;
      end
      BL_DIV: begin
        // restoring division, one quotient bit per cycle
        if (!trial[33]) begin
          rem_q <= trial[31:0];
          quo_q <= {quo_q[30:0], 1'b1};
        end else begin
          rem_q <= {rem_q[30:0], quo_q[31]};
          quo_q <= {quo_q[30:0], 1'b0};
        end
        cnt_q <= cnt_q - 5'd1;
      end
      BL_FIN: result_q <= tli_sat32(fin);
      default: ;
    endcase
  end

  assign done_o   = (state_q == BL_DONE);
  assign result_o = result_q;

  `TLI_ASSERT_IMP(a_start_idle, start_i, state_q == BL_IDLE, "blend started while busy")
  `TLI_ASSERT_IMP(a_rem_below_d, state_q == BL_DIV, rem_q < d_q, "divider remainder overflow")
  `TLI_ASSERT_IMP(a_done_path, done_o, $past(state_q == BL_FIN) || (d_q == 32'd0),
                  "blend done without finishing divide")

endmodule

>>> rtl/trajectory_linear_interpolator.sv
// Top level of the trajectory linear interpolator: point table, scan, blend.
// Uses tli_pkg, tli_point_ram, tli_blend_unit and assert_macros.svh.
//
//   channel | signals                                   | role
//   --------+-------------------------------------------+------------------------
//   in      | in_valid_i, in_stall_o, kind_i, point_*_i | begin / append / query
//   out     | out_valid_o, out_stall_i, *_out_o, status | one word per query
//   config  | psel, penable, pwrite, paddr, pwdata, ... | start state registers
//
// Begin and append finish as they are accepted. A query scans the table from entry 0
// at one entry per cycle through the single read port of the point RAM, then runs
// three blends through one serial divider if it finds the segment.
// Reset clears the point count and start time, but not the RAM, which needs no clearing.
// A finished word sits in the output register while the next item is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module trajectory_linear_interpolator #(
  parameter int MAX_POINTS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] point_position_i,
  input  logic [31:0] point_velocity_i,
  input  logic [31:0] point_effort_i,
  input  logic [31:0] segment_duration_i,
  input  logic [62:0] time_stamp_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] position_out_o,
  output logic [31:0] velocity_out_o,
  output logic [31:0] effort_out_o,
  output logic [1:0]  status_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tli_pkg::*;

  localparam int AW   = $clog2(MAX_POINTS);
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int CW   = 32 + AW;        // cumulative time width
  localparam int EW   = 128 + CW;       // RAM word: pos, vel, eff, seg, cum

  // ---------------- configuration registers ----------------
  logic [31:0] start_pos_q, start_vel_q, start_eff_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_pos_q <= '0;
      start_vel_q <= '0;
      start_eff_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_START_POS: start_pos_q <= pwdata;
        REG_START_VEL: start_vel_q <= pwdata;
        REG_START_EFF: start_eff_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_START_POS: prdata = start_pos_q;
      REG_START_VEL: prdata = start_vel_q;
      REG_START_EFF: prdata = start_eff_q;
      default:       prdata = 32'd0;
    endcase
  end

  // ---------------- control state ----------------
  tli_state_e state_q, state_d;

  logic [CNTW-1:0] cnt_q;        // points in table
  logic [CW-1:0]   run_sum_q;    // cumulative time of last point
  logic [62:0]     start_time_q;
  logic [62:0]     el_q;         // elapsed time of current query
  logic [CNTW-1:0] issue_q;      // next RAM read address
  logic [AW-1:0]   chk_q;        // index of word arriving from RAM
  logic            data_vld_q;
  logic [EW-1:0]   prev_q;       // entry chk_q - 1
  logic [31:0]     a_q [3];
  logic [31:0]     b_q [3];
  logic [31:0]     n_q, d_q;
  logic [1:0]      ch_q;
  logic            go_q;
  logic [31:0]     res_q [3];
  logic [1:0]      stat_q;

  logic        out_valid_q;
  logic [31:0] pos_out_q, vel_out_q, eff_out_q;
  logic [1:0]  status_q;

  // ---------------- RAM ----------------
  logic          wr_en, rd_en;
  logic [EW-1:0] wr_data, rd_data;
  logic [CW-1:0] cum_new;

  logic in_acc;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  assign cum_new = run_sum_q + {{AW{1'b0}}, segment_duration_i};
  assign wr_en   = in_acc && (kind_i == KIND_APPEND) && (cnt_q < CNTW'(MAX_POINTS));
  assign wr_data = {cum_new, segment_duration_i, point_effort_i,
                    point_velocity_i, point_position_i};
  assign rd_en   = (state_q == ST_SCAN) && (issue_q < cnt_q);

  tli_point_ram #(
    .DEPTH(MAX_POINTS),
    .WIDTH(EW)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(cnt_q[AW-1:0]),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(issue_q[AW-1:0]),
    .rd_data_o(rd_data)
  );

  // RAM word fields
  logic [31:0]   rd_pos, rd_vel, rd_eff, rd_seg;
  logic [CW-1:0] rd_cum, prev_cum;
  assign rd_pos   = rd_data[31:0];
  assign rd_vel   = rd_data[63:32];
  assign rd_eff   = rd_data[95:64];
  assign rd_seg   = rd_data[127:96];
  assign rd_cum   = rd_data[EW-1:128];
  assign prev_cum = prev_q[EW-1:128];

  // ---------------- scan decisions ----------------
  logic [CNTW-1:0] last_cnt;
  logic            hit, is_last, stop, first;
  logic [CW-1:0]   seg_base, n_full;
  logic [62:0]     elapsed;

  assign last_cnt = cnt_q - CNTW'(1);
  assign hit      = {{(63 - CW){1'b0}}, rd_cum} > el_q;
  assign is_last  = (chk_q == last_cnt[AW-1:0]);
  assign stop     = data_vld_q && (hit || is_last);
  assign first    = (chk_q == '0);
  assign seg_base = first ? '0 : prev_cum;
  assign n_full   = el_q[CW-1:0] - seg_base;
  assign elapsed  = (time_stamp_i >= start_time_q) ? (time_stamp_i - start_time_q) : '0;

  // ---------------- blend unit ----------------
  logic        blend_done;
  logic [31:0] blend_res;

  tli_blend_unit u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (go_q),
    .a_i     (a_q[ch_q]),
    .b_i     (b_q[ch_q]),
    .n_i     (n_q),
    .d_i     (d_q),
    .done_o  (blend_done),
    .result_o(blend_res)
  );

  logic out_free;
  assign out_free = ~out_valid_q | ~out_stall_i;

  // ---------------- FSM ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (kind_i == KIND_QUERY)) begin
          state_d = (cnt_q == '0) ? ST_OUT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stop) state_d = hit ? ST_BLEND : ST_OUT;
      end
      ST_BLEND: begin
        if (blend_done && (ch_q == 2'd2)) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      run_sum_q    <= '0;
      start_time_q <= '0;
      data_vld_q   <= 1'b0;
      issue_q      <= '0;
      go_q         <= 1'b0;
      ch_q         <= 2'd0;
      out_valid_q  <= 1'b0;
    end else begin
      // blend start: first channel after the scan hit, then each next channel
      go_q <= ((state_q == ST_SCAN) && stop && hit) ||
              ((state_q == ST_BLEND) && blend_done && (ch_q != 2'd2));
      if (in_acc && (kind_i == KIND_BEGIN)) begin
        cnt_q        <= '0;
        run_sum_q    <= '0;
        start_time_q <= time_stamp_i;
      end
      if (wr_en) begin
        cnt_q     <= cnt_q + CNTW'(1);
        run_sum_q <= cum_new;
      end
      if (in_acc && (kind_i == KIND_QUERY)) begin
        issue_q    <= '0;
        data_vld_q <= 1'b0;
      end
      if (state_q == ST_SCAN) begin
        data_vld_q <= rd_en & ~stop;
        if (rd_en) issue_q <= issue_q + CNTW'(1);
        if (stop && hit) begin
          ch_q <= 2'd0;
        end
      end
      if ((state_q == ST_BLEND) && blend_done && (ch_q != 2'd2)) begin
        ch_q <= ch_q + 2'd1;
      end
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (~out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc && (kind_i == KIND_QUERY)) begin
      el_q      <= elapsed;
      res_q[0]  <= '0;
      res_q[1]  <= '0;
      res_q[2]  <= '0;
      stat_q    <= STAT_EMPTY;
    end
    if (state_q == ST_SCAN) begin
      chk_q <= issue_q[AW-1:0];
      if (data_vld_q && !stop) prev_q <= rd_data;
      if (stop) begin
        if (hit) begin
          a_q[0] <= first ? start_pos_q : prev_q[31:0];
          a_q[1] <= first ? start_vel_q : prev_q[63:32];
          a_q[2] <= first ? start_eff_q : prev_q[95:64];
          b_q[0] <= rd_pos;
          b_q[1] <= rd_vel;
          b_q[2] <= rd_eff;
          n_q    <= n_full[31:0];
          d_q    <= rd_seg;
          stat_q <= STAT_INTERP;
        end else begin
          // at or past the end: hold the final point
          res_q[0] <= rd_pos;
          res_q[1] <= rd_vel;
          res_q[2] <= rd_eff;
          stat_q   <= STAT_HELD;
        end
      end
    end
    if ((state_q == ST_BLEND) && blend_done) begin
      res_q[ch_q] <= blend_res;
    end
    if ((state_q == ST_OUT) && out_free) begin
      pos_out_q <= res_q[0];
      vel_out_q <= res_q[1];
      eff_out_q <= res_q[2];
      status_q  <= stat_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign position_out_o = pos_out_q;
  assign velocity_out_o = vel_out_q;
  assign effort_out_o   = eff_out_q;
  assign status_o       = status_q;

  `TLI_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNTW'(MAX_POINTS), "point count over capacity")
  `TLI_ASSERT_IMP(a_out_load, $rose(out_valid_o), $past(state_q == ST_OUT),
                  "output word loaded outside output state")
  `TLI_ASSERT_IMP(a_blend_owner, blend_done, state_q == ST_BLEND,
                  "blend finished outside blend state")

endmodule
